@@ src/mwce_pkg.sv @@
// Shared types and constants for the melt wipe column engine.
// No dependencies; the top level and the testbench import this package.
package mwce_pkg;

	// Widths fixed by the stream and register formats.
	localparam int FIELD_W     = 14;
	localparam int COL_IDX_W   = 8;
	localparam int RAND_W      = 8;
	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 64;
	localparam int CFG_INDEX_W = 1;
	localparam int REQ_W       = 2;

	// Request kinds carried in the input tuser.
	localparam logic [REQ_W-1:0] REQ_SEED  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

	// Register indexes on the configuration channel.
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [FIELD_W-1:0] SCREEN_WIDTH_RST  = 14'd320;
	localparam logic [FIELD_W-1:0] SCREEN_HEIGHT_RST = 14'd200;

	// Melt rule constants.
	localparam int SEED_DEPTH = 15;
	localparam int FAST_LIMIT = 16;
	localparam int SLOW_STEP  = 8;

	typedef logic signed [4:0] seed_val_t;

endpackage

@@ src/mwce_cell.sv @@
// One cell of the circulating column chain: holds the position of one strip.
// Standalone; instantiated once per strip by the top level.
module mwce_cell #(
	parameter int PW        = 10,
	parameter int RESET_VAL = 200
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift,
	input  logic signed [PW-1:0] d,
	output logic signed [PW-1:0] q
);

	logic signed [PW-1:0] pos_q;

	// Every cell takes its neighbour's value while the chain turns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= PW'(RESET_VAL);
		end else if (shift) begin
			pos_q <= d;
		end
	end

	assign q = pos_q;

endmodule

@@ src/mwce_cdiv.sv @@
// Division by a fixed divisor through a rounded-up reciprocal multiplication.
// Standalone; the top level uses one per scaled coordinate.
module mwce_cdiv #(
	parameter int NW      = 23,
	parameter int DIVISOR = 160
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic [NW-1:0] dividend,
	output logic          done,
	output logic [NW-1:0] quotient
);

	// With SH = NW + clog2(DIVISOR), (x * MAGIC) >> SH equals x / DIVISOR for every NW-bit x.
	localparam int          SH      = NW + $clog2(DIVISOR);
	localparam logic [63:0] MAGIC64 = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [NW:0] MAGIC   = MAGIC64[NW:0];
	localparam int          PROD_W  = 2 * NW + 1;

	logic              run_q;
	logic [NW-1:0]     dvd_q;
	logic [NW-1:0]     quo_q;
	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(dvd_q) * PROD_W'(MAGIC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= load;
		end
	end

	// The dividend is registered first, the scaled product in the cycle after.
	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
		end
		if (run_q) begin
			quo_q <= NW'(prod >> SH);
		end
	end

	assign done     = !run_q;
	assign quotient = quo_q;

endmodule

@@ src/melt_wipe_column_engine_top.sv @@
// Melt wipe column engine: top level with the column chain, sequencer and scaling.
// Depends on mwce_pkg, mwce_cell and mwce_cdiv.
//
// Usage. Items arrive on the s_axis stream; tuser selects seed, tick or query.
// Every accepted item gives exactly one result transfer on m_axis.
// The strip positions sit in a ring of COLUMNS cells. Each item turns the ring
// once, one strip a cycle, and the strip passing the head is seeded, advanced
// by the melt rule or captured for a query on its way round.
// An item turns the ring after its transfer, then its result is loaded; a query
// for a strip in range first passes a multiply step and the reciprocal dividers.
// One item is worked on at a time: s_axis_tready is high only between items, so
// a new item is taken only once the result of the last one is loaded.
// The result waits in an output register, so a new item is taken while it is
// pending; a stalled receiver holds the engine only when the next result is ready.
// Reset sets every strip to the finished height, clears the seed state and
// restores the screen size to 320 by 200. Configuration writes are always
// taken and must only be made while no item is in flight.
module melt_wipe_column_engine_top #(
	parameter int COLUMNS      = 160,
	parameter int STRIP_HEIGHT = 200
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// rand_byte [7:0], column_index [15:8]
	input  logic [mwce_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// req_type [1:0], restart [2]
	input  logic [mwce_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// done_res [0], strip_left [14:1], strip_right [28:15], strip_top [42:29],
	// strip_span [56:43], visible [57], zero [63:58]
	output logic [mwce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mwce_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mwce_pkg::FIELD_W-1:0]        cfg_data
);

	import mwce_pkg::*;

	localparam int POS_UW = $clog2(STRIP_HEIGHT + 1);
	localparam int PW     = POS_UW + 1;
	localparam int IDXW   = $clog2(COLUMNS);
	localparam int CNTW   = $clog2(COLUMNS + 1);
	localparam int PRODA_W = COL_IDX_W + 1 + FIELD_W;
	localparam int PRODC_W = POS_UW + FIELD_W;
	localparam int NW     = (PRODA_W > PRODC_W) ? PRODA_W : PRODC_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ROTATE = 2'd1;
	localparam logic [1:0] ST_MUL    = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	localparam logic signed [PW:0] SH_W   = (PW + 1)'(STRIP_HEIGHT);
	localparam logic signed [PW:0] FAST_W = (PW + 1)'(FAST_LIMIT);
	localparam logic signed [PW:0] SLOW_W = (PW + 1)'(SLOW_STEP);
	localparam logic signed [PW:0] ONE_W  = (PW + 1)'(1);
	localparam logic signed [5:0]  SEED_LO = -6'(SEED_DEPTH);
	localparam logic [IDXW-1:0]    LAST_K  = IDXW'(COLUMNS - 1);

	function automatic logic [1:0] mod3_byte(input logic [RAND_W-1:0] b);
		logic [3:0] s;
		logic [1:0] r;
		begin
			// 4 is 1 modulo 3, so the base-4 digit sum keeps the remainder.
			s = {2'b00, b[1:0]} + {2'b00, b[3:2]} + {2'b00, b[5:4]} + {2'b00, b[7:6]};
			case (s) inside
				4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
				4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
				default:                       r = 2'd2;
			endcase
			return r;
		end
	endfunction

	logic [1:0]           state_q;
	logic [FIELD_W-1:0]   width_q;
	logic [FIELD_W-1:0]   height_q;
	seed_val_t            seed_prev_q;
	logic [CNTW-1:0]      seed_idx_q;
	logic [REQ_W-1:0]     req_q;
	logic [COL_IDX_W-1:0] col_q;
	logic                 wr_en_q;
	logic [IDXW-1:0]      wr_idx_q;
	seed_val_t            wr_val_q;
	logic [IDXW-1:0]      k_q;
	logic                 moved_q;
	logic                 div_run_q;
	logic signed [PW-1:0] cap_pos_q;
	logic                 m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	logic signed [PW-1:0] cell_q [COLUMNS];
	logic signed [PW-1:0] head_nxt;
	logic                 head_chg;
	logic                 shift;
	logic                 in_xfer;
	logic [REQ_W-1:0]     in_req;
	logic                 in_restart;
	logic [RAND_W-1:0]    in_rand;
	seed_val_t            seed_rst_val;
	seed_val_t            seed_step_val;
	logic signed [5:0]    seed_sum;
	logic                 col_ok;
	logic                 div_load;
	logic [NW-1:0]        dvd_a, dvd_b, dvd_c;
	logic [NW-1:0]        quo_a, quo_b, quo_c;
	logic                 done_a, done_b, done_c;
	logic                 out_free;
	logic                 res_load;
	logic [OUT_TDATA_W-1:0] result;

	assign in_xfer    = s_axis_tvalid && s_axis_tready;
	assign in_req     = s_axis_tuser[1:0];
	assign in_restart = s_axis_tuser[2];
	assign in_rand    = s_axis_tdata[7:0];
	assign shift      = (state_q == ST_ROTATE);
	assign out_free   = !m_valid_q || m_axis_tready;
	assign res_load   = (state_q == ST_FINISH) && out_free;
	assign col_ok     = (32'(col_q) < COLUMNS);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;

	// Seed values worked out at the transfer of a seed item.
	always_comb begin
		seed_rst_val = 5'd0 - {1'b0, in_rand[3:0]};
		seed_sum     = {seed_prev_q[4], seed_prev_q} + {4'b0000, mod3_byte(in_rand)} - 6'd1;
		if (seed_sum < SEED_LO) begin
			seed_step_val = SEED_LO[4:0];
		end else if (!seed_sum[5] && (seed_sum != 6'd0)) begin
			seed_step_val = 5'd0;
		end else begin
			seed_step_val = seed_sum[4:0];
		end
	end

	// Head of the ring: the strip leaving cell 0 is rewritten on its way to the tail.
	always_comb begin
		logic signed [PW:0] pe;
		logic signed [PW:0] dy;
		logic signed [PW:0] np;
		logic signed [PW:0] tick_nxt;
		pe       = {cell_q[0][PW-1], cell_q[0]};
		dy       = SLOW_W;
		np       = pe;
		tick_nxt = pe;
		head_chg = 1'b0;
		if (pe[PW]) begin
			tick_nxt = pe + ONE_W;
			head_chg = 1'b1;
		end else if (pe < SH_W) begin
			dy       = (pe < FAST_W) ? pe + ONE_W : SLOW_W;
			np       = pe + dy;
			tick_nxt = (np > SH_W) ? SH_W : np;
			head_chg = 1'b1;
		end
		case (req_q)
			REQ_TICK: head_nxt = tick_nxt[PW-1:0];
			REQ_SEED: head_nxt = (wr_en_q && (k_q == wr_idx_q)) ?
				{{(PW - 5){wr_val_q[4]}}, wr_val_q} : cell_q[0];
			default:  head_nxt = cell_q[0];
		endcase
	end

	for (genvar j = 0; j < COLUMNS; j++) begin : g_ring
		logic signed [PW-1:0] d;
		if (j == COLUMNS - 1) begin : g_tail
			assign d = head_nxt;
		end else begin : g_link
			assign d = cell_q[j + 1];
		end
		mwce_cell #(
			.PW        (PW),
			.RESET_VAL (STRIP_HEIGHT)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (cell_q[j])
		);
	end

	// Products for the scaled coordinates; each is registered in its divider.
	assign div_load = (state_q == ST_MUL) && !div_run_q;
	assign dvd_a = NW'(col_q) * NW'(width_q);
	assign dvd_b = (NW'(col_q) + NW'(1)) * NW'(width_q);
	assign dvd_c = cap_pos_q[PW-1] ? '0 : NW'(cap_pos_q[PW-2:0]) * NW'(height_q);

	mwce_cdiv #(.NW(NW), .DIVISOR(COLUMNS)) u_div_left (
		.clk (clk), .arst_n (arst_n), .load (div_load),
		.dividend (dvd_a), .done (done_a), .quotient (quo_a)
	);

	mwce_cdiv #(.NW(NW), .DIVISOR(COLUMNS)) u_div_right (
		.clk (clk), .arst_n (arst_n), .load (div_load),
		.dividend (dvd_b), .done (done_b), .quotient (quo_b)
	);

	mwce_cdiv #(.NW(NW), .DIVISOR(STRIP_HEIGHT)) u_div_top (
		.clk (clk), .arst_n (arst_n), .load (div_load),
		.dividend (dvd_c), .done (done_c), .quotient (quo_c)
	);

	// Result word; fields that the item kind does not use stay zero.
	always_comb begin
		logic               q_ok;
		logic [FIELD_W-1:0] left, right, top, span;
		logic               done_res;
		q_ok     = (req_q == REQ_QUERY) && col_ok;
		left     = q_ok ? quo_a[FIELD_W-1:0] : '0;
		right    = q_ok ? quo_b[FIELD_W-1:0] : '0;
		top      = q_ok ? quo_c[FIELD_W-1:0] : '0;
		span     = q_ok ? height_q - top : '0;
		done_res = (req_q == REQ_TICK) && !moved_q;
		result   = {6'd0, (span != '0), span, top, right, left, done_res};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCREEN_WIDTH_RST;
			height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_prev_q <= '0;
			seed_idx_q  <= '0;
			req_q       <= REQ_NONE;
			wr_en_q     <= 1'b0;
			k_q         <= '0;
			moved_q     <= 1'b0;
			div_run_q   <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						req_q   <= in_req;
						k_q     <= '0;
						moved_q <= 1'b0;
						wr_en_q <= (in_req == REQ_SEED) &&
							(in_restart || (seed_idx_q < CNTW'(COLUMNS)));
						state_q <= ST_ROTATE;
						if (in_req == REQ_SEED) begin
							if (in_restart) begin
								seed_prev_q <= seed_rst_val;
								seed_idx_q  <= CNTW'(1);
							end else if (seed_idx_q < CNTW'(COLUMNS)) begin
								seed_prev_q <= seed_step_val;
								seed_idx_q  <= seed_idx_q + CNTW'(1);
							end
						end
					end
				end
				ST_ROTATE: begin
					if (req_q == REQ_TICK && head_chg) begin
						moved_q <= 1'b1;
					end
					if (k_q == LAST_K) begin
						k_q     <= '0;
						state_q <= (req_q == REQ_QUERY && col_ok) ? ST_MUL : ST_FINISH;
					end else begin
						k_q <= k_q + IDXW'(1);
					end
				end
				ST_MUL: begin
					// The first cycle loads the dividers; the flag marks the wait after it.
					if (!div_run_q) begin
						div_run_q <= 1'b1;
					end else if (done_a && done_b && done_c) begin
						div_run_q <= 1'b0;
						state_q   <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_q    <= s_axis_tdata[15:8];
			wr_idx_q <= in_restart ? '0 : seed_idx_q[IDXW-1:0];
			wr_val_q <= in_restart ? seed_rst_val : seed_step_val;
		end
		if (shift && (32'(k_q) == 32'(col_q))) begin
			cap_pos_q <= cell_q[0];
		end
		if (res_load) begin
			m_data_q <= result;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

@@ tb/sv/melt_wipe_column_engine_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for melt_wipe_column_engine_top: seed, tick and query streams
// checked against a behavioural model of the strip ring. Depends on mwce_pkg and the RTL.
module melt_wipe_column_engine_top_test;
	import mwce_pkg::*;

	localparam int COLUMNS      = 160;
	localparam int STRIP_HEIGHT = 200;
	localparam int CLK_PERIOD   = 20;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int HOLD_CYCLES  = 1500;
	localparam int TAIL_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;
	localparam int N_PHASES     = 8;

	// Matches the m_axis_tdata layout, highest field first.
	typedef struct packed {
		logic [5:0]         pad;
		logic               visible;
		logic [FIELD_W-1:0] strip_span;
		logic [FIELD_W-1:0] strip_top;
		logic [FIELD_W-1:0] strip_right;
		logic [FIELD_W-1:0] strip_left;
		logic               done;
	} strip_result_t;

	class melt_scoreboard;
		logic signed [8:0]  strip_pos [COLUMNS];
		seed_val_t          seed_last;
		logic [7:0]         seed_next;
		logic [FIELD_W-1:0] width_px;
		logic [FIELD_W-1:0] height_px;
		strip_result_t      expected_q [$];
		int failures, results_checked;
		int n_seed, n_tick, n_query, n_other, n_done;

		function new();
			for (int i = 0; i < COLUMNS; i++)
				strip_pos[i] = 9'(STRIP_HEIGHT);
			seed_last = '0;
			seed_next = '0;
			width_px  = SCREEN_WIDTH_RST;
			height_px = SCREEN_HEIGHT_RST;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [FIELD_W-1:0] value);
			if (idx == REG_SCREEN_WIDTH)
				width_px = value;
			else if (idx == REG_SCREEN_HEIGHT)
				height_px = value;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function bit melt_finished();
			for (int i = 0; i < COLUMNS; i++)
				if (strip_pos[i] < STRIP_HEIGHT)
					return 1'b0;
			return 1'b1;
		endfunction

		function void note_input(logic [REQ_W-1:0] kind, logic [7:0] rnd, logic restart_bit,
			logic [7:0] col);
			strip_result_t want;
			int p, np, v;
			int unsigned l, r, t, s;
			bit moved;
			want = '0;
			case (kind)
				REQ_SEED: begin
					n_seed++;
					if (restart_bit) begin
						v = -int'(rnd[3:0]);
						seed_last = seed_val_t'(v);
						strip_pos[0] = 9'(v);
						seed_next = 8'd1;
					end else if (seed_next < COLUMNS) begin
						v = int'(seed_last) + int'(rnd) % 3 - 1;
						if (v < -SEED_DEPTH)
							v = -SEED_DEPTH;
						if (v > 0)
							v = 0;
						seed_last = seed_val_t'(v);
						strip_pos[seed_next] = 9'(v);
						seed_next++;
					end
				end
				REQ_TICK: begin
					n_tick++;
					moved = 1'b0;
					for (int i = 0; i < COLUMNS; i++) begin
						p = strip_pos[i];
						if (p < 0) begin
							strip_pos[i] = 9'(p + 1);
							moved = 1'b1;
						end else if (p < STRIP_HEIGHT) begin
							np = p + ((p < FAST_LIMIT) ? p + 1 : SLOW_STEP);
							strip_pos[i] = 9'((np > STRIP_HEIGHT) ? STRIP_HEIGHT : np);
							moved = 1'b1;
						end
					end
					want.done = !moved;
					if (!moved)
						n_done++;
				end
				REQ_QUERY: begin
					n_query++;
					if (col < COLUMNS) begin
						p = strip_pos[col];
						l = (int'(col) * int'(width_px)) / COLUMNS;
						r = ((int'(col) + 1) * int'(width_px)) / COLUMNS;
						t = (p > 0) ? (p * int'(height_px)) / STRIP_HEIGHT : 0;
						s = (t <= height_px) ? height_px - t : 0;
						want.strip_left  = l[FIELD_W-1:0];
						want.strip_right = r[FIELD_W-1:0];
						want.strip_top   = t[FIELD_W-1:0];
						want.strip_span  = s[FIELD_W-1:0];
						want.visible     = (s != 0);
					end
				end
				default: n_other++;
			endcase
			expected_q.push_back(want);
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got)
				note_failure($sformatf("result %0d %s: expected %0d, got %0d",
					results_checked, name, want, got));
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] tdata);
			strip_result_t got, want;
			got = strip_result_t'(tdata);
			results_checked++;
			if (expected_q.size() == 0) begin
				note_failure($sformatf("result %0d arrived with nothing outstanding: %h",
					results_checked, tdata));
				return;
			end
			want = expected_q.pop_front();
			compare_field("done_res", want.done, got.done);
			compare_field("strip_left", want.strip_left, got.strip_left);
			compare_field("strip_right", want.strip_right, got.strip_right);
			compare_field("strip_top", want.strip_top, got.strip_top);
			compare_field("strip_span", want.strip_span, got.strip_span);
			compare_field("visible", want.visible, got.visible);
			compare_field("padding", want.pad, got.pad);
		endfunction
	endclass

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_TDATA_W-1:0]    s_axis_tdata  = '0;
	logic [IN_TUSER_W-1:0]    s_axis_tuser  = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]   m_axis_tdata;
	logic                     cfg_valid     = 1'b0;
	logic                     cfg_ready;
	logic [CFG_INDEX_W-1:0]   cfg_index     = '0;
	logic [FIELD_W-1:0]       cfg_data      = '0;

	melt_scoreboard sb = new();
	int src_idle_pct = 9;
	int dst_idle_pct = 74;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycle_count = 0;

	melt_wipe_column_engine_top #(
		.COLUMNS      (COLUMNS),
		.STRIP_HEIGHT (STRIP_HEIGHT)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver keeps its own count of a long hold-off once one is asked for.
	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// tvalid stays high after a transfer until the next falling edge decides what follows.
	task automatic send_item(input logic [REQ_W-1:0] kind, input logic [7:0] rnd,
		input logic restart_bit, input logic [7:0] col);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {col, rnd};
		s_axis_tuser  <= {restart_bit, kind};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(kind, rnd, restart_bit, col);
	endtask

	task automatic send_query();
		logic [7:0] col;
		col = ($urandom_range(19) == 0) ? 8'($urandom_range(255, COLUMNS))
			: 8'($urandom_range(COLUMNS - 1));
		send_item(REQ_QUERY, 8'($urandom), 1'($urandom), col);
	endtask

	task automatic send_noise();
		send_item(REQ_W'($urandom_range(3)), 8'($urandom), 1'($urandom), 8'($urandom));
	endtask

	// Stops offering and waits for every outstanding result.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [FIELD_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_register(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One melt: a restarting seed, seed_count further seeds, then ticks until it reports done.
	task automatic run_melt(input int seed_count);
		send_item(REQ_SEED, 8'($urandom), 1'b1, 8'($urandom));
		for (int n = 0; n < seed_count; n++) begin
			if ($urandom_range(99) < 7)
				send_query();
			if ($urandom_range(99) < 2)
				send_noise();
			send_item(REQ_SEED, 8'($urandom), 1'b0, 8'($urandom));
		end
		while (!sb.melt_finished()) begin
			if ($urandom_range(99) < 30)
				send_query();
			if ($urandom_range(99) < 3)
				send_noise();
			send_item(REQ_TICK, 8'($urandom), 1'($urandom), 8'($urandom));
		end
		send_item(REQ_TICK, 8'($urandom), 1'($urandom), 8'($urandom));
	endtask

	task automatic run_directed();
		send_item(REQ_QUERY, 8'h00, 1'b0, 8'd0);
		send_item(REQ_QUERY, 8'hFF, 1'b1, 8'(COLUMNS - 1));
		send_item(REQ_QUERY, 8'h00, 1'b0, 8'(COLUMNS));
		send_item(REQ_QUERY, 8'h00, 1'b0, 8'hFF);
		send_item(REQ_TICK, 8'h00, 1'b0, 8'h00);
		send_item(REQ_NONE, 8'hFF, 1'b1, 8'hFF);
		// Seeding without a restart straight after reset starts from strip zero.
		send_item(REQ_SEED, 8'hFE, 1'b0, 8'h00);
		send_item(REQ_SEED, 8'h00, 1'b0, 8'h00);
		send_item(REQ_SEED, 8'hFF, 1'b1, 8'h00);
		send_item(REQ_SEED, 8'hFF, 1'b0, 8'hFF);
		send_item(REQ_SEED, 8'h01, 1'b0, 8'h00);
		send_item(REQ_SEED, 8'h02, 1'b0, 8'h00);
		send_item(REQ_SEED, 8'h10, 1'b1, 8'h00);
		send_item(REQ_QUERY, 8'h00, 1'b0, 8'd0);
		send_item(REQ_TICK, 8'hFF, 1'b1, 8'hFF);
		send_item(REQ_QUERY, 8'h00, 1'b0, 8'd0);
		send_item(REQ_TICK, 8'h00, 1'b0, 8'h00);
		send_item(REQ_QUERY, 8'h00, 1'b0, 8'd1);
		send_item(REQ_QUERY, 8'h00, 1'b0, 8'd2);
		send_item(REQ_NONE, 8'h00, 1'b0, 8'h00);
		send_item(REQ_TICK, 8'h00, 1'b0, 8'h00);
	endtask

	initial begin
		logic [FIELD_W-1:0] width_set [N_PHASES];
		logic [FIELD_W-1:0] height_set [N_PHASES];
		int seeds;
		width_set  = '{14'd0, 14'd16383, 14'd1, 14'd8192, 14'd640, 14'd320, 14'd160,
			14'($urandom_range(8192, 1))};
		height_set = '{14'd0, 14'd16383, 14'd1, 14'd8192, 14'd480, 14'd200, 14'd199,
			14'($urandom_range(8192, 1))};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 3) begin
				src_idle_pct = 9;
				dst_idle_pct = 74;
			end else if (ph < 6) begin
				src_idle_pct = 74;
				dst_idle_pct = 9;
			end else begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			drain();
			write_reg(REG_SCREEN_WIDTH, width_set[ph]);
			write_reg(REG_SCREEN_HEIGHT, height_set[ph]);
			// The first melt runs the seeding past the last strip.
			if (ph == 0)
				seeds = COLUMNS + 2;
			else if ($urandom_range(4) == 0)
				seeds = $urandom_range(COLUMNS + 5, 20);
			else
				seeds = COLUMNS - 1;
			run_melt(seeds);
			if (ph == 1) begin
				// Long receiver stall while the sender keeps offering, so the input backs up.
				hold_requests++;
				repeat (6)
					send_query();
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d seeds, %0d ticks, %0d queries and %0d unknown requests;",
			sb.n_seed, sb.n_tick, sb.n_query, sb.n_other);
		$display("%0d melts reported finished across %0d screen sizes, %0d results checked.",
			sb.n_done, N_PHASES + 1, sb.results_checked);
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
